// ===== rtl/mf3_pkg.sv =====
// mf3_pkg: shared types, sizes and register indexes for the 3x3 median filter.
// Used by mf3_median and median_filter_3x3; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mf3_pkg;

  localparam int MaxWidth = 1024;              // longest supported row
  localparam int ColW     = $clog2(MaxWidth);  // line store address bits
  localparam int PixW     = 8;
  localparam int DimW     = 11;                // size register width

  localparam logic [DimW-1:0] WidthReset  = DimW'(256);
  localparam logic [DimW-1:0] HeightReset = DimW'(256);
  localparam logic [DimW-1:0] DimMin      = DimW'(2);
  localparam logic [DimW-1:0] WidthMax    = DimW'(MaxWidth);

  typedef logic [PixW-1:0] pix_t;
  // window entry k*3+j: row k (0 = oldest), column j (2 = newest)
  typedef pix_t [8:0] win_t;

  typedef enum logic {
    CfgImageWidth  = 1'b0,
    CfgImageHeight = 1'b1
  } cfg_idx_e;

endpackage

`default_nettype wire

// ===== rtl/mf3_ram.sv =====
// mf3_ram: generic simple dual-port RAM, one write and one registered read port.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module mf3_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/mf3_median.sv =====
// mf3_median: combinational median of nine pixels (row sort, then cross medians).
// Depends on mf3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mf3_median (
  input  wire mf3_pkg::win_t win_i,
  output mf3_pkg::pix_t      median_o
);
  import mf3_pkg::*;

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  pix_t lo  [3];
  pix_t mid [3];
  pix_t hi  [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lo[k]  = min2(min2(win_i[k*3], win_i[k*3+1]), win_i[k*3+2]);
      mid[k] = med3(win_i[k*3], win_i[k*3+1], win_i[k*3+2]);
      hi[k]  = max2(max2(win_i[k*3], win_i[k*3+1]), win_i[k*3+2]);
    end
  end

  // largest of the row minima, median of row medians, smallest of row maxima
  assign median_o = med3(max2(max2(lo[0], lo[1]), lo[2]),
                         med3(mid[0], mid[1], mid[2]),
                         min2(min2(hi[0], hi[1]), hi[2]));

endmodule

`default_nettype wire

// ===== rtl/median_filter_3x3.sv =====
// median_filter_3x3: streaming 3x3 median filter, replicated border, raster order.
// A result goes through the s1 and out registers to m_axis. Throughput: one input
// transfer per cycle, set by the single-pass window update and the one-read/one-write
// line store RAMs, except that input stalls while s1 and the output register both
// hold results and m_axis_tready is low. Reset clears counters, window and pipeline
// valids; the line stores are not cleared. Depends on mf3_pkg, mf3_ram, mf3_median.
`timescale 1ns / 1ps
`default_nettype none

module median_filter_3x3 (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration write port
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_index_i,
  input  wire logic [mf3_pkg::DimW-1:0] cfg_data_i,
  // input stream
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire logic [7:0]               s_axis_tdata,   // [7:0] pixel_value
  input  wire logic                     s_axis_tuser,   // [0] opcode (1 = flush)
  // output stream
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // [7:0] median_value
  output logic                          m_axis_tlast    // last_of_frame
);
  import mf3_pkg::*;

  // size registers
  logic [DimW-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgImageWidth:  width_q  <= cfg_data_i;
        CfgImageHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped sizes
  logic [DimW-1:0] w_eff, h_eff;
  assign w_eff = (width_q < DimMin) ? DimMin : (width_q > WidthMax) ? WidthMax : width_q;
  assign h_eff = (height_q < DimMin) ? DimMin : height_q;

  // raster position and window
  logic [ColW-1:0] col_q, col_d;
  logic [DimW-1:0] row_q, row_d;
  win_t            win_q, win_d;

  // pipeline: s1 holds the window to reduce, out holds the result
  logic s1_valid_q, s1_valid_d, s1_last_q;
  win_t s1_win_q;
  logic out_valid_q, out_last_q;
  pix_t out_data_q, median;

  logic adv_out, in_ready, acc;
  assign adv_out  = !out_valid_q || m_axis_tready;
  assign in_ready = !s1_valid_q || adv_out;
  assign acc      = s_axis_tvalid && in_ready;

  // step decode
  logic  flush, draining, final_out, ignore;
  pix_t  pix, rd_upper, rd_lower;
  pix_t  taps [3];
  logic  ls_we;
  pix_t  wr_upper;
  win_t  win_new, win_edge, res_win;
  logic  res_edge, res_mid, res_valid, res_last;
  logic  col_wrap;

  assign flush     = s_axis_tuser;
  assign pix       = s_axis_tdata;
  assign draining  = row_q >= h_eff;
  assign final_out = {1'b0, row_q} >= ({1'b0, h_eff} + (DimW+1)'(1));
  assign ignore    = !draining && flush;   // flush tick while rows still arrive
  assign col_wrap  = (DimW'(col_q) + DimW'(1)) >= w_eff;

  always_comb begin
    // column taps: oldest row first
    if (draining) begin
      taps[0] = rd_upper;
      taps[1] = rd_lower;
      taps[2] = rd_lower;  // bottom border replicates the last row
    end else if (row_q == '0) begin
      taps[0] = pix;
      taps[1] = pix;
      taps[2] = pix;       // top border replicates the first row
    end else begin
      taps[0] = rd_upper;
      taps[1] = rd_lower;
      taps[2] = pix;
    end

    for (int k = 0; k < 3; k++) begin
      if (col_q == '0) begin
        win_new[k*3]   = taps[k];
        win_new[k*3+1] = taps[k];
      end else begin
        win_new[k*3]   = win_q[k*3+1];
        win_new[k*3+1] = win_q[k*3+2];
      end
      win_new[k*3+2] = taps[k];
      // right border: replicate the newest column of the current window
      win_edge[k*3]   = win_q[k*3+1];
      win_edge[k*3+1] = win_q[k*3+2];
      win_edge[k*3+2] = win_q[k*3+2];
    end
  end

  assign ls_we    = acc && !draining && !flush;
  assign wr_upper = (row_q == '0) ? pix : rd_lower;

  assign res_edge = (col_q == '0) && (row_q >= DimW'(2));
  assign res_mid  = (col_q != '0) && (row_q != '0);

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    win_d     = win_q;
    res_valid = 1'b0;
    res_last  = 1'b0;
    res_win   = win_new;
    if (final_out) begin
      res_valid = 1'b1;
      res_last  = 1'b1;
      res_win   = win_edge;
      if (acc) begin
        col_d = '0;
        row_d = '0;
      end
    end else if (!ignore) begin
      res_valid = res_edge || res_mid;
      res_win   = res_edge ? win_edge : win_new;
      if (acc) begin
        win_d = win_new;
        if (col_wrap) begin
          col_d = '0;
          row_d = row_q + DimW'(1);
        end else begin
          col_d = col_q + ColW'(1);
        end
      end
    end
  end

  assign s1_valid_d = in_ready ? (acc && res_valid) : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      win_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      win_q      <= win_d;
      s1_valid_q <= s1_valid_d;
      if (adv_out) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready) begin
      s1_win_q  <= res_win;
      s1_last_q <= res_last;
    end
    if (adv_out) begin
      out_data_q <= median;
      out_last_q <= s1_last_q;
    end
  end

  // line stores read one column ahead, so the data for col_q is ready on transfer
  mf3_ram #(.Width(PixW), .Depth(MaxWidth)) u_ls_upper (
    .clk_i   (clk_i),
    .we_i    (ls_we),
    .waddr_i (col_q),
    .wdata_i (wr_upper),
    .raddr_i (col_d),
    .rdata_o (rd_upper)
  );

  mf3_ram #(.Width(PixW), .Depth(MaxWidth)) u_ls_lower (
    .clk_i   (clk_i),
    .we_i    (ls_we),
    .waddr_i (col_q),
    .wdata_i (pix),
    .raddr_i (col_d),
    .rdata_o (rd_lower)
  );

  mf3_median u_median (
    .win_i    (s1_win_q),
    .median_o (median)
  );

  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire
